// ===== hdl/rpwbd_pkg.sv =====
package rpwbd_pkg;

  // Field widths fixed by the interface
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned CODE_W  = 36;
  localparam int unsigned IDX_W   = 1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PULSE_LENGTH = 1'd0;
  localparam logic [IDX_W-1:0] REG_TOLERANCE    = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] PULSE_LENGTH_RST = 14'd1000;
  localparam logic [CFG_W-1:0] TOLERANCE_RST    = 14'd300;

  // Window hits for one pulse, from the window unit to the frame unit
  typedef struct packed {
    logic long_hit;   // inside 2*length +/- tolerance: zero bit
    logic short_hit;  // inside length +/- tolerance: one bit
  } pulse_class_t;

endpackage

// ===== hdl/rf_pulse_width_bit_decoder_unit.sv =====
// Pulse-width bit decoder for a 36-bit OOK sensor frame. Each input transfer
// carries one measured high-pulse width; a width in the long window
// (2*pulse_length +/- tolerance) is a zero bit, a width in the short window
// (pulse_length +/- tolerance) is a one bit whose following pulse is skipped,
// and anything else aborts the packet with a zero code and decoded_ok low.
// After FRAME_BITS bits one result transfer carries the code, first bit in
// the MSB. packet_start restarts decoding; incomplete packets give nothing.
// Timing: an item is taken into an input register, decoded while it is held
// there and the result lands in an output register; one item is accepted per
// cycle while the output register is not stalled. The window bounds are
// registered from the config registers, so an item should follow a config
// write by at least one cycle.
module rf_pulse_width_bit_decoder_unit #(
  parameter int unsigned FRAME_BITS = 36
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rpwbd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rpwbd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rpwbd_pkg::PULSE_W-1:0]      pulse_width,
  input  logic                               packet_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rpwbd_pkg::CODE_W-1:0]       decoded_code,
  output logic                               decoded_ok
);

  // Input stage register
  logic                            stage_valid;
  logic [rpwbd_pkg::PULSE_W-1:0]   stage_width;
  logic                            stage_start;
  logic                            advance;
  logic                            fire;
  logic                            in_accept;
  rpwbd_pkg::pulse_class_t         pclass;

  assign fire      = stage_valid && advance;
  assign in_stall  = stage_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_width <= pulse_width;
      stage_start <= packet_start;
    end
  end

  // Window classification
  rpwbd_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .width     (stage_width),
    .pclass    (pclass)
  );

  // Bit assembly and result register
  rpwbd_frame #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .start        (stage_start),
    .pclass       (pclass),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .decoded_code (decoded_code),
    .decoded_ok   (decoded_ok)
  );

endmodule

// ===== hdl/rpwbd_window.sv =====
module rpwbd_window (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rpwbd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rpwbd_pkg::CFG_W-1:0]        cfg_data,
  input  logic [rpwbd_pkg::PULSE_W-1:0]      width,
  output rpwbd_pkg::pulse_class_t            pclass
);

  logic [rpwbd_pkg::CFG_W-1:0] pulse_length;
  logic [rpwbd_pkg::CFG_W-1:0] tolerance;

  // Window bounds, registered from the config registers
  logic [13:0] min1;
  logic [14:0] max1;
  logic [14:0] min2;
  logic [15:0] max2;

  logic [13:0] min1_next;
  logic [14:0] max1_next;
  logic [14:0] min2_next;
  logic [15:0] max2_next;
  logic [14:0] twice_len;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_length <= rpwbd_pkg::PULSE_LENGTH_RST;
      tolerance    <= rpwbd_pkg::TOLERANCE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rpwbd_pkg::REG_PULSE_LENGTH: pulse_length <= cfg_data;
        rpwbd_pkg::REG_TOLERANCE:    tolerance    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bound arithmetic, lower bounds clamp at zero
  always_comb begin
    twice_len = {pulse_length, 1'b0};
    min1_next = (pulse_length > tolerance) ? (pulse_length - tolerance) : 14'd0;
    max1_next = {1'b0, pulse_length} + {1'b0, tolerance};
    min2_next = (twice_len > {1'b0, tolerance}) ? (twice_len - {1'b0, tolerance}) : 15'd0;
    max2_next = {1'b0, twice_len} + {2'b00, tolerance};
  end

  always_ff @(posedge clk) begin
    min1 <= min1_next;
    max1 <= max1_next;
    min2 <= min2_next;
    max2 <= max2_next;
  end

  // Inclusive window compares
  always_comb begin
    pclass.long_hit  = (width >= {1'b0, min2}) && (width <= max2);
    pclass.short_hit = (width >= {2'b00, min1}) && (width <= {1'b0, max1});
  end

endmodule

// ===== hdl/rpwbd_frame.sv =====
module rpwbd_frame #(
  parameter int unsigned FRAME_BITS = 36
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  logic                               start,
  input  rpwbd_pkg::pulse_class_t            pclass,
  output logic                               advance,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rpwbd_pkg::CODE_W-1:0]       decoded_code,
  output logic                               decoded_ok
);

  localparam int unsigned CNT_W  = $clog2(FRAME_BITS + 1);
  localparam int unsigned WIDE_W = (FRAME_BITS > rpwbd_pkg::CODE_W) ? FRAME_BITS
                                                                     : rpwbd_pkg::CODE_W;

  // Decoder state
  logic [CNT_W-1:0]      bit_count;
  logic [FRAME_BITS-1:0] shift_bits;
  logic                  skip_next;
  logic                  aborted;

  logic [CNT_W-1:0]      bit_count_next;
  logic [FRAME_BITS-1:0] shift_bits_next;
  logic                  skip_next_next;
  logic                  aborted_next;
  logic                  emit;
  logic [FRAME_BITS-1:0] emit_frame;
  logic                  emit_ok;
  logic [CNT_W:0]        count_inc;
  logic [WIDE_W-1:0]     wide_frame;

  // Output register frees up when empty or being drained
  assign advance = !(out_valid && out_stall);

  // Per-pulse decode step
  always_comb begin
    bit_count_next  = bit_count;
    shift_bits_next = shift_bits;
    skip_next_next  = skip_next;
    aborted_next    = aborted;
    emit            = 1'b0;
    emit_frame      = '0;
    emit_ok         = 1'b0;
    count_inc       = '0;
    if (start) begin
      bit_count_next  = '0;
      shift_bits_next = '0;
      skip_next_next  = 1'b0;
      aborted_next    = 1'b0;
    end
    if (aborted_next) begin
      // idle until a packet start
    end else if (skip_next_next) begin
      skip_next_next = 1'b0;
    end else if (pclass.long_hit || pclass.short_hit) begin
      shift_bits_next = FRAME_BITS'({shift_bits_next, !pclass.long_hit});
      skip_next_next  = !pclass.long_hit;
      count_inc       = {1'b0, bit_count_next} + 1'b1;
      if (count_inc >= (CNT_W + 1)'(FRAME_BITS)) begin
        emit            = 1'b1;
        emit_frame      = shift_bits_next;
        emit_ok         = |shift_bits_next;
        bit_count_next  = '0;
        skip_next_next  = 1'b0;
        aborted_next    = 1'b1;
      end else begin
        bit_count_next = count_inc[CNT_W-1:0];
      end
    end else begin
      // bad width: report an empty frame and go idle
      emit            = 1'b1;
      shift_bits_next = '0;
      bit_count_next  = '0;
      skip_next_next  = 1'b0;
      aborted_next    = 1'b1;
    end
  end

  assign wide_frame = WIDE_W'(emit_frame);

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count  <= '0;
      shift_bits <= '0;
      skip_next  <= 1'b0;
      aborted    <= 1'b1;
    end else if (fire) begin
      bit_count  <= bit_count_next;
      shift_bits <= shift_bits_next;
      skip_next  <= skip_next_next;
      aborted    <= aborted_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      decoded_code <= wide_frame[rpwbd_pkg::CODE_W-1:0];
      decoded_ok   <= emit_ok;
    end
  end

endmodule
